FILE: sv/window_and_set_statistics_macros.svh
// Assertion macros shared by the window and set statistics RTL.
// Each macro expands to one labeled concurrent assertion on the given clock and reset.
`ifndef WINDOW_AND_SET_STATISTICS_MACROS_SVH
`define WINDOW_AND_SET_STATISTICS_MACROS_SVH

// Condition holds at every edge outside reset.
`define WSS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define WSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/wsst_pkg.sv
// Package for the window and set statistics block: widths, codes and payload types.
// Used by wsst_front, wsst_queue, wsst_back and the top level.
`timescale 1ns / 1ps

package wsst_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int WIN_LEN_W   = 11;
   localparam int WINDOW_MAX  = 1024;
   localparam int MAX_SAMPLES = 1048576;
   localparam int WIN_SUM_W   = 27;
   localparam int SET_CNT_W   = 21;
   localparam int SET_SUM_W   = 37;
   localparam int SET_SQ_W    = 51;
   localparam int MEAN_W      = 24;
   localparam int SD_W        = 24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int DIV_W       = 88;
   localparam int DEN_W       = 41;
   localparam int DIV_CNT_W   = 7;
   localparam int PROD_W      = 72;
   localparam int MULB_W      = 36;
   localparam int ROOT_W      = 48;

   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_SET    = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_set;
   } req_type;

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] win_min;
      logic signed [SAMPLE_W-1:0] win_max;
      logic signed [MEAN_W-1:0]   win_mean_q8;
      logic signed [MEAN_W-1:0]   set_mean_q8;
      logic        [SD_W-1:0]     set_sd_q8;
      logic                       sd_valid;
      logic                       overflow;
      logic                       last_result;
   } rsp_type;

   // One finished window or set, handed from the front to the back.
   typedef struct packed {
      logic                        kind;
      logic                        last;
      logic signed [SAMPLE_W-1:0]  win_min;
      logic signed [SAMPLE_W-1:0]  win_max;
      logic signed [SET_SUM_W-1:0] total;
      logic        [SET_CNT_W-1:0] count;
      logic        [SET_SQ_W-1:0]  square;
      logic                        overflow;
   } job_type;

endpackage

FILE: sv/wsst_front.sv
// Front end: takes samples, keeps window and set accumulators, emits finished jobs.
// Depends on wsst_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "window_and_set_statistics_macros.svh"

module wsst_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wsst_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wsst_pkg::WIN_LEN_W-1:0]      csr_data,
   input  logic                                q_space,
   output logic                                push0,
   output logic                                push1,
   output wsst_pkg::job_type                   job0,
   output wsst_pkg::job_type                   job1
);

   logic [wsst_pkg::WIN_LEN_W-1:0]        window_length_ff, window_length_in;
   logic [wsst_pkg::WIN_LEN_W-1:0]        win_count_ff, win_count_in;
   logic signed [wsst_pkg::SAMPLE_W-1:0]  win_low_ff, win_low_in;
   logic signed [wsst_pkg::SAMPLE_W-1:0]  win_high_ff, win_high_in;
   logic signed [wsst_pkg::WIN_SUM_W-1:0] win_total_ff, win_total_in;
   logic [wsst_pkg::SET_CNT_W-1:0]        set_count_ff, set_count_in;
   logic signed [wsst_pkg::SET_SUM_W-1:0] set_total_ff, set_total_in;
   logic [wsst_pkg::SET_SQ_W-1:0]         set_square_ff, set_square_in;
   logic                                  set_ovf_ff, set_ovf_in;

   logic [wsst_pkg::WIN_LEN_W-1:0]        len_eff;
   logic                                  accept;
   logic signed [wsst_pkg::SAMPLE_W-1:0]  x;
   logic [wsst_pkg::SAMPLE_W-1:0]         ax;
   logic [2*wsst_pkg::SAMPLE_W-1:0]       x_sq;
   logic [wsst_pkg::WIN_LEN_W-1:0]        cnt_new;
   logic signed [wsst_pkg::SAMPLE_W-1:0]  low_new, high_new;
   logic signed [wsst_pkg::WIN_SUM_W-1:0] total_new;
   logic                                  win_done, eos, full;
   logic [wsst_pkg::SET_CNT_W-1:0]        scnt_new;
   logic signed [wsst_pkg::SET_SUM_W-1:0] stot_new;
   logic [wsst_pkg::SET_SQ_W-1:0]         ssq_new;
   logic                                  sovf_new;
   wsst_pkg::job_type                     win_job, set_job;

   assign csr_ready = 1'b1;
   assign req_stall = !q_space;
   assign accept    = req_valid && !req_stall;
   assign x         = req_data.sample;
   assign eos       = req_data.end_of_set;

   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = wsst_pkg::WIN_LEN_W'(1);
      end else if (window_length_ff > wsst_pkg::WIN_LEN_W'(wsst_pkg::WINDOW_MAX)) begin
         len_eff = wsst_pkg::WIN_LEN_W'(wsst_pkg::WINDOW_MAX);
      end else begin
         len_eff = window_length_ff;
      end

      cnt_new   = win_count_ff + wsst_pkg::WIN_LEN_W'(1);
      win_done  = cnt_new >= len_eff;
      low_new   = (win_count_ff == '0 || x < win_low_ff) ? x : win_low_ff;
      high_new  = (win_count_ff == '0 || x > win_high_ff) ? x : win_high_ff;
      total_new = win_total_ff + wsst_pkg::WIN_SUM_W'(x);

      ax   = x[wsst_pkg::SAMPLE_W-1] ? wsst_pkg::SAMPLE_W'(-x) : wsst_pkg::SAMPLE_W'(x);
      x_sq = ax * ax;
      full = set_count_ff >= wsst_pkg::SET_CNT_W'(wsst_pkg::MAX_SAMPLES);
      if (full) begin
         scnt_new = set_count_ff;
         stot_new = set_total_ff;
         ssq_new  = set_square_ff;
      end else begin
         scnt_new = set_count_ff + wsst_pkg::SET_CNT_W'(1);
         stot_new = set_total_ff + wsst_pkg::SET_SUM_W'(x);
         ssq_new  = set_square_ff + wsst_pkg::SET_SQ_W'(x_sq);
      end
      sovf_new = set_ovf_ff || full;

      win_job          = '0;
      win_job.kind     = wsst_pkg::KIND_WINDOW;
      win_job.last     = !eos;
      win_job.win_min  = low_new;
      win_job.win_max  = high_new;
      win_job.total    = wsst_pkg::SET_SUM_W'(total_new);
      win_job.count    = wsst_pkg::SET_CNT_W'(cnt_new);

      set_job          = '0;
      set_job.kind     = wsst_pkg::KIND_SET;
      set_job.last     = 1'b1;
      set_job.total    = stot_new;
      set_job.count    = scnt_new;
      set_job.square   = ssq_new;
      set_job.overflow = sovf_new;

      job0  = win_done ? win_job : set_job;
      job1  = set_job;
      push0 = accept && (win_done || eos);
      push1 = accept && win_done && eos;

      window_length_in = (csr_valid && csr_ready) ? csr_data : window_length_ff;

      win_count_in  = win_count_ff;
      win_low_in    = win_low_ff;
      win_high_in   = win_high_ff;
      win_total_in  = win_total_ff;
      set_count_in  = set_count_ff;
      set_total_in  = set_total_ff;
      set_square_in = set_square_ff;
      set_ovf_in    = set_ovf_ff;
      if (accept) begin
         if (win_done || eos) begin
            win_count_in = '0;
            win_low_in   = '0;
            win_high_in  = '0;
            win_total_in = '0;
         end else begin
            win_count_in = cnt_new;
            win_low_in   = low_new;
            win_high_in  = high_new;
            win_total_in = total_new;
         end
         if (eos) begin
            set_count_in  = '0;
            set_total_in  = '0;
            set_square_in = '0;
            set_ovf_in    = 1'b0;
         end else begin
            set_count_in  = scnt_new;
            set_total_in  = stot_new;
            set_square_in = ssq_new;
            set_ovf_in    = sovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= wsst_pkg::WIN_LEN_W'(8);
         win_count_ff     <= '0;
         win_low_ff       <= '0;
         win_high_ff      <= '0;
         win_total_ff     <= '0;
         set_count_ff     <= '0;
         set_total_ff     <= '0;
         set_square_ff    <= '0;
         set_ovf_ff       <= 1'b0;
      end else begin
         window_length_ff <= window_length_in;
         win_count_ff     <= win_count_in;
         win_low_ff       <= win_low_in;
         win_high_ff      <= win_high_in;
         win_total_ff     <= win_total_in;
         set_count_ff     <= set_count_in;
         set_total_ff     <= set_total_in;
         set_square_ff    <= set_square_in;
         set_ovf_ff       <= set_ovf_in;
      end
   end

   `WSS_ASSERT_ALWAYS(a_win_count_range, clock, reset,
      win_count_ff < wsst_pkg::WIN_LEN_W'(wsst_pkg::WINDOW_MAX), "window count out of range")
   `WSS_ASSERT_IMPLIES(a_set_count_cap, clock, reset, set_ovf_ff,
      set_count_ff == wsst_pkg::SET_CNT_W'(wsst_pkg::MAX_SAMPLES), "overflow below capacity")

endmodule

FILE: sv/wsst_queue.sv
// Short job queue between front and back; takes up to two jobs per cycle, gives one.
// Depends on wsst_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "window_and_set_statistics_macros.svh"

module wsst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push0,
   input  logic              push1,
   input  wsst_pkg::job_type job0,
   input  wsst_pkg::job_type job1,
   output logic              space,
   input  logic              pop,
   output logic              not_empty,
   output wsst_pkg::job_type head
);

   wsst_pkg::job_type                mem_ff [wsst_pkg::QUEUE_DEPTH];
   logic [wsst_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [wsst_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [wsst_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_pop;
   logic [wsst_pkg::QPTR_W-1:0]      wr_ptr_b;

   assign not_empty = count_ff != '0;
   assign space     = count_ff <= wsst_pkg::QCNT_W'(wsst_pkg::QUEUE_DEPTH - 2);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign wr_ptr_b  = wr_ptr_ff + wsst_pkg::QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + wsst_pkg::QPTR_W'(push0) + wsst_pkg::QPTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + wsst_pkg::QPTR_W'(do_pop);
      count_in  = count_ff + wsst_pkg::QCNT_W'(push0) + wsst_pkg::QCNT_W'(push1)
                  - wsst_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= job0;
      end
      if (push1) begin
         mem_ff[wr_ptr_b] <= job1;
      end
   end

   `WSS_ASSERT_ALWAYS(a_queue_count, clock, reset,
      count_ff <= wsst_pkg::QCNT_W'(wsst_pkg::QUEUE_DEPTH), "queue count past depth")
   `WSS_ASSERT_IMPLIES(a_push_order, clock, reset, push1, push0, "second push without first")

endmodule

FILE: sv/wsst_back.sv
// Back end: turns queued jobs into results with a serial divider, multiplier and root.
// Depends on wsst_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "window_and_set_statistics_macros.svh"

module wsst_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  wsst_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsst_pkg::rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MEAN  = 3'd1;
   localparam logic [2:0] S_SQ    = 3'd2;
   localparam logic [2:0] S_NS2   = 3'd3;
   localparam logic [2:0] S_NN    = 3'd4;
   localparam logic [2:0] S_SDDIV = 3'd5;
   localparam logic [2:0] S_ROOT  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                        state_ff, state_in;
   wsst_pkg::job_type                 job_ff, job_in;
   logic                              neg_ff, neg_in;
   logic [wsst_pkg::SET_SUM_W-1:0]    mag_ff, mag_in;
   logic [wsst_pkg::DIV_W-1:0]        div_num_ff, div_num_in;
   logic [wsst_pkg::DEN_W-1:0]        div_rem_ff, div_rem_in;
   logic [wsst_pkg::DEN_W-1:0]        div_den_ff, div_den_in;
   logic [wsst_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [wsst_pkg::PROD_W-1:0]       mul_a_ff, mul_a_in;
   logic [wsst_pkg::MULB_W-1:0]       mul_b_ff, mul_b_in;
   logic [wsst_pkg::PROD_W-1:0]       acc_ff, acc_in;
   logic [wsst_pkg::PROD_W-1:0]       sq_ff, sq_in;
   logic [wsst_pkg::ROOT_W-1:0]       rt_v_ff, rt_v_in;
   logic [wsst_pkg::ROOT_W-1:0]       rt_res_ff, rt_res_in;
   logic [wsst_pkg::ROOT_W-1:0]       rt_bit_ff, rt_bit_in;
   logic [wsst_pkg::MEAN_W-1:0]       mean_ff, mean_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   wsst_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [wsst_pkg::DEN_W:0]          rem_sh;
   logic                              div_ge;
   logic [wsst_pkg::DEN_W-1:0]        div_rem_nx;
   logic [wsst_pkg::DIV_W-1:0]        div_num_nx;
   logic [wsst_pkg::PROD_W-1:0]       acc_nx;
   logic [wsst_pkg::ROOT_W-1:0]       rt_trial;
   logic                              rt_ge;
   logic [wsst_pkg::SET_SUM_W-1:0]    head_mag;
   logic [wsst_pkg::PROD_W-1:0]       diff;
   logic [wsst_pkg::MEAN_W-1:0]       q_mean;
   logic                              sd_needed;
   logic                              out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // restoring divider step
      rem_sh     = {div_rem_ff, div_num_ff[wsst_pkg::DIV_W-1]};
      div_ge     = rem_sh >= {1'b0, div_den_ff};
      div_rem_nx = div_ge ? wsst_pkg::DEN_W'(rem_sh - {1'b0, div_den_ff})
                          : wsst_pkg::DEN_W'(rem_sh);
      div_num_nx = {div_num_ff[wsst_pkg::DIV_W-2:0], div_ge};
      // shift-add multiplier step
      acc_nx     = acc_ff + (mul_b_ff[0] ? mul_a_ff : '0);
      // digit-by-digit root step
      rt_trial   = rt_res_ff + rt_bit_ff;
      rt_ge      = rt_v_ff >= rt_trial;

      head_mag   = q_head.total[wsst_pkg::SET_SUM_W-1] ? wsst_pkg::SET_SUM_W'(-q_head.total)
                                                       : wsst_pkg::SET_SUM_W'(q_head.total);
      diff       = (acc_ff >= sq_ff) ? acc_ff - sq_ff : '0;
      q_mean     = div_num_ff[wsst_pkg::MEAN_W-1:0];
      sd_needed  = job_ff.kind == wsst_pkg::KIND_SET
                   && job_ff.count >= wsst_pkg::SET_CNT_W'(2);

      state_in     = state_ff;
      job_in       = job_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      cnt_in       = cnt_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rt_v_in      = rt_v_ff;
      rt_res_in    = rt_res_ff;
      rt_bit_in    = rt_bit_ff;
      mean_in      = mean_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop      = 1'b1;
               job_in     = q_head;
               neg_in     = q_head.total[wsst_pkg::SET_SUM_W-1];
               mag_in     = head_mag;
               // round half away: (mag*512 + n) / (2n)
               div_num_in = wsst_pkg::DIV_W'({head_mag, 9'b0})
                            + wsst_pkg::DIV_W'(q_head.count);
               div_den_in = wsst_pkg::DEN_W'({q_head.count, 1'b0});
               div_rem_in = '0;
               cnt_in     = wsst_pkg::DIV_CNT_W'(wsst_pkg::DIV_W);
               state_in   = S_MEAN;
            end
         end
         S_MEAN: begin
            if (cnt_ff != '0) begin
               div_num_in = div_num_nx;
               div_rem_in = div_rem_nx;
               cnt_in     = cnt_ff - wsst_pkg::DIV_CNT_W'(1);
            end else begin
               if (job_ff.count == '0) begin
                  mean_in = '0;
               end else begin
                  mean_in = neg_ff ? wsst_pkg::MEAN_W'(-q_mean) : q_mean;
               end
               rt_res_in = '0;
               if (sd_needed) begin
                  mul_a_in = wsst_pkg::PROD_W'(mag_ff);
                  mul_b_in = wsst_pkg::MULB_W'(mag_ff);
                  acc_in   = '0;
                  state_in = S_SQ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SQ: begin
            if (mul_b_ff != '0) begin
               acc_in   = acc_nx;
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else begin
               sq_in    = acc_ff;
               mul_a_in = wsst_pkg::PROD_W'(job_ff.square);
               mul_b_in = wsst_pkg::MULB_W'(job_ff.count);
               acc_in   = '0;
               state_in = S_NS2;
            end
         end
         S_NS2: begin
            if (mul_b_ff != '0) begin
               acc_in   = acc_nx;
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else begin
               div_num_in = {diff[wsst_pkg::DIV_W-17:0], 16'b0};
               mul_a_in   = wsst_pkg::PROD_W'(job_ff.count);
               mul_b_in   = wsst_pkg::MULB_W'(job_ff.count - wsst_pkg::SET_CNT_W'(1));
               acc_in     = '0;
               state_in   = S_NN;
            end
         end
         S_NN: begin
            if (mul_b_ff != '0) begin
               acc_in   = acc_nx;
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else begin
               div_den_in = acc_ff[wsst_pkg::DEN_W-1:0];
               div_rem_in = '0;
               cnt_in     = wsst_pkg::DIV_CNT_W'(wsst_pkg::DIV_W);
               state_in   = S_SDDIV;
            end
         end
         S_SDDIV: begin
            if (cnt_ff != '0) begin
               div_num_in = div_num_nx;
               div_rem_in = div_rem_nx;
               cnt_in     = cnt_ff - wsst_pkg::DIV_CNT_W'(1);
            end else begin
               rt_v_in   = div_num_ff[wsst_pkg::ROOT_W-1:0];
               rt_res_in = '0;
               rt_bit_in = {2'b01, {(wsst_pkg::ROOT_W-2){1'b0}}};
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            if (rt_bit_ff != '0) begin
               if (rt_ge) begin
                  rt_v_in   = rt_v_ff - rt_trial;
                  rt_res_in = (rt_res_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_res_in = rt_res_ff >> 1;
               end
               rt_bit_in = rt_bit_ff >> 2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.kind        = job_ff.kind;
               rsp_in.last_result = job_ff.last;
               if (job_ff.kind == wsst_pkg::KIND_WINDOW) begin
                  rsp_in.win_min     = job_ff.win_min;
                  rsp_in.win_max     = job_ff.win_max;
                  rsp_in.win_mean_q8 = mean_ff;
               end else begin
                  rsp_in.set_mean_q8 = mean_ff;
                  rsp_in.set_sd_q8   = rt_res_ff[wsst_pkg::SD_W-1:0];
                  rsp_in.sd_valid    = sd_needed;
                  rsp_in.overflow    = job_ff.overflow;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      cnt_ff     <= cnt_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      rt_v_ff    <= rt_v_in;
      rt_res_ff  <= rt_res_in;
      rt_bit_ff  <= rt_bit_in;
      mean_ff    <= mean_in;
      rsp_ff     <= rsp_in;
   end

   `WSS_ASSERT_IMPLIES(a_sd_path_set_only, clock, reset,
      (state_ff == S_SQ || state_ff == S_NS2 || state_ff == S_NN || state_ff == S_SDDIV
       || state_ff == S_ROOT), sd_needed, "deviation path entered without two set samples")
   `WSS_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, q_pop,
      (state_ff == S_IDLE && q_not_empty), "job taken while busy")

endmodule

FILE: sv/window_and_set_statistics.sv
// Window and set statistics over a stream of signed 16-bit samples.
//
// req channel (req_valid / req_stall / req_data): one sample with its end-of-set mark per
// transfer. Each full window of window_length samples (clamped to 1..1024) yields a window
// result (min, max, Q8 mean); a sample marked end_of_set yields a set result (Q8 mean, Q8
// sample standard deviation, sd_valid, overflow) after any window result of the same sample.
// rsp channel (rsp_valid / rsp_stall / rsp_data): one result per transfer, last_result
// marks the final result caused by a sample. csr channel: writes window_length, always ready.
// The front accepts one sample per cycle unless stalled; finished windows and sets go
// through a four-entry job queue to a back end with a serial divider, shift-add multiplier
// and root unit. A window result needs only the mean divide in the back end; a set result
// of two or more samples adds the deviation divide, the three multiplies and the root.
// The front keeps taking samples while the back end works and stalls only when the queue
// cannot take two more jobs.
// A stalled rsp holds its result; the back end finishes the next job and waits behind it.
// Reset (synchronous) sets window_length to 8 and clears all accumulators and the queue.
// Depends on wsst_pkg, wsst_front, wsst_queue and wsst_back.
`timescale 1ns / 1ps

module window_and_set_statistics (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wsst_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wsst_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wsst_pkg::WIN_LEN_W-1:0] csr_data
);

   logic              push0, push1, q_space, q_pop, q_not_empty;
   wsst_pkg::job_type job0, job1, q_head;

   wsst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_space   (q_space),
      .push0     (push0),
      .push1     (push1),
      .job0      (job0),
      .job1      (job1)
   );

   wsst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .job0      (job0),
      .job1      (job1),
      .space     (q_space),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   wsst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
